// ----- rtl/core/kprd_pkg.sv -----
package kprd_pkg;

  // Fixed field widths
  localparam int KEY_INPUTS  = 28;
  localparam int KEY_INDEX_W = 5;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 8;

  // Defaults for the top-level parameters
  localparam int NUM_KEYS_DEF    = 28;
  localparam int COUNT_WIDTH_DEF = 16;

  // Event queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TIME       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_LIMIT      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_SPEED_PERIOD = 8'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] FILTER_TIME_RST       = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_LIMIT_RST      = 16'd5;
  localparam logic [CFG_W-1:0] HIGH_SPEED_PERIOD_RST = 16'd100;

  typedef enum logic [1:0] {
    EV_PRESS = 2'd0,
    EV_LONG  = 2'd1,
    EV_FAST  = 2'd2,
    EV_LEAVE = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [KEY_INDEX_W-1:0] key;
    ev_kind_t               kind;
    logic                   last;
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] filter_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] repeat_limit;
    logic [CFG_W-1:0] high_speed_period;
  } cfg_t;

endpackage

// ----- rtl/core/keypad_press_repeat_detector.sv -----
// Keypad press / long-press / repeat detector.
//
// Tick channel (tick_valid / tick_stall / pressed_keys): one request per scan
// tick, one pressed bit per key. A request is taken when tick_valid is high
// and tick_stall is low. Each tick walks every key once, one key per cycle
// unless the walk pauses for a full event queue, through the per-key state
// store (one read and one write port). A tick occupies the walk until every
// key is processed and its last event is flushed, and longer while the
// event queue stays full and an event of that tick waits for room.
// Event channel (event_valid / event_stall / key_index / event_kind /
// last_event): zero to NUM_KEYS requests per tick, in key order; last_event
// marks the final event of a tick. An event is held back until the next
// event of the tick or the end of the walk, so that its last flag is known.
// Receiver stalls fill the short event queue; then the walk pauses, and
// tick_stall stays high until the tick is finished. No event is dropped.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; indexes 0..3 pick filter, long-press, repeat-limit and high-speed
// registers, other indexes are ignored. Write only while idle.
// Reset: all keys go idle, registers take their defaults. No clearing pass.
module keypad_press_repeat_detector #(
  parameter int NUM_KEYS    = kprd_pkg::NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = kprd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  output logic                             tick_stall,
  input  logic [kprd_pkg::KEY_INPUTS-1:0]  pressed_keys,
  output logic                             event_valid,
  input  logic                             event_stall,
  output logic [kprd_pkg::KEY_INDEX_W-1:0] key_index,
  output logic [1:0]                       event_kind,
  output logic                             last_event,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kprd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kprd_pkg::CFG_W-1:0]       cfg_data
);
  import kprd_pkg::*;

  cfg_t   cfg;
  logic   push;
  event_t push_data;
  logic   q_full;
  logic   pop;
  event_t head;
  logic   q_empty;

  // config registers are shared by every key
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_time       <= FILTER_TIME_RST;
      cfg.long_press_time   <= LONG_PRESS_TIME_RST;
      cfg.repeat_limit      <= REPEAT_LIMIT_RST;
      cfg.high_speed_period <= HIGH_SPEED_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_TIME:       cfg.filter_time       <= cfg_data;
        REG_LONG_PRESS_TIME:   cfg.long_press_time   <= cfg_data;
        REG_REPEAT_LIMIT:      cfg.repeat_limit      <= cfg_data;
        REG_HIGH_SPEED_PERIOD: cfg.high_speed_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: takes ticks, walks the keys, classifies events
  kprd_front #(
    .NUM_KEYS    (NUM_KEYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .pressed_keys (pressed_keys),
    .cfg          (cfg),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  // short queue decouples the walk from the receiver
  kprd_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // back: output register toward the receiver
  kprd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .key_index   (key_index),
    .event_kind  (event_kind),
    .last_event  (last_event)
  );

endmodule

// ----- rtl/core/kprd_front.sv -----
module kprd_front #(
  parameter int NUM_KEYS    = kprd_pkg::NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = kprd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  logic [kprd_pkg::KEY_INPUTS-1:0] pressed_keys,
  input  kprd_pkg::cfg_t                  cfg,
  output logic                            push,
  output kprd_pkg::event_t                push_data,
  input  logic                            q_full
);
  import kprd_pkg::*;

  localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int NW = $clog2(NUM_KEYS + 1);
  localparam int MW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [NW-1:0] LAST_CNT = NW'(NUM_KEYS);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PFILT = 3'd1,
    PH_DOWN  = 3'd2,
    PH_LONG  = 3'd3,
    PH_FAST  = 3'd4,
    PH_RFILT = 3'd5,
    PH_RDONE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WALK,
    F_FLUSH
  } fstate_t;

  fstate_t state;

  // per-key state store
  logic [2:0]             phase_mem [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] tick_mem  [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] rep_mem   [NUM_KEYS];
  logic [NUM_KEYS-1:0]    key_vld;

  logic [KEY_INPUTS-1:0]  keys;
  logic [NW-1:0]          rd_cnt;
  logic [IW-1:0]          rd_addr;
  logic                   rd_en;
  logic                   wr_en;

  // processing stage
  logic                   p_valid;
  logic                   p_seen;
  logic [IW-1:0]          p_idx;
  logic [2:0]             rd_phase;
  logic [COUNT_WIDTH-1:0] rd_tick;
  logic [COUNT_WIDTH-1:0] rd_rep;
  phase_t                 cur_phase;
  logic [NUM_KEYS-1:0]    down_all;
  logic                   down;

  // held event, pushed once the next one (or the end of the walk) is known
  logic                   hold_valid;
  logic [KEY_INDEX_W-1:0] hold_key;
  ev_kind_t               hold_kind;

  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0] rep_inc;
  logic [MW-1:0]          tick_w;
  logic [MW-1:0]          rep_w;
  logic [MW-1:0]          filt_w;
  logic [MW-1:0]          lp_w;
  logic [MW-1:0]          rl_w;
  logic [MW-1:0]          hs_w;
  logic                   lp_on;
  logic                   rl_on;
  logic                   hs_on;

  phase_t                 ph_next;
  logic [COUNT_WIDTH-1:0] tick_next;
  logic [COUNT_WIDTH-1:0] rep_next;
  logic                   ev_hit;
  ev_kind_t               ev_kind;
  logic                   ev_now;
  logic                   adv;
  logic                   tick_acc;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_down
    if (k < KEY_INPUTS) begin : g_in
      assign down_all[k] = keys[k];
    end else begin : g_none
      assign down_all[k] = 1'b0;
    end
  end

  assign down      = down_all[p_idx];
  assign cur_phase = p_seen ? phase_t'(rd_phase) : PH_IDLE;

  assign tick_inc = (&rd_tick) ? rd_tick : rd_tick + COUNT_WIDTH'(1);
  assign rep_inc  = (&rd_rep) ? rd_rep : rd_rep + COUNT_WIDTH'(1);
  assign tick_w   = MW'(tick_inc);
  assign rep_w    = MW'(rep_inc);
  assign filt_w   = MW'(cfg.filter_time);
  assign lp_w     = MW'(cfg.long_press_time);
  assign rl_w     = MW'(cfg.repeat_limit);
  assign hs_w     = MW'(cfg.high_speed_period);
  assign lp_on    = (cfg.long_press_time != '0);
  assign rl_on    = (cfg.repeat_limit != '0);
  assign hs_on    = (cfg.high_speed_period != '0);

  // one key, one tick
  always_comb begin
    ph_next   = cur_phase;
    tick_next = rd_tick;
    rep_next  = rd_rep;
    ev_hit    = 1'b0;
    ev_kind   = EV_PRESS;
    case (cur_phase)
      PH_IDLE: begin
        tick_next = '0;
        if (down) begin
          tick_next = COUNT_WIDTH'(1);
          ph_next   = PH_PFILT;
        end
      end
      PH_PFILT: begin
        tick_next = tick_inc;
        if (tick_w >= filt_w) begin
          if (!down) begin
            ph_next = PH_IDLE;
          end else begin
            ev_hit  = 1'b1;
            ev_kind = EV_PRESS;
            ph_next = PH_DOWN;
          end
        end
      end
      PH_DOWN: begin
        if (down) begin
          tick_next = tick_inc;
          if (lp_on && tick_w >= lp_w) begin
            ev_hit    = 1'b1;
            ev_kind   = EV_LONG;
            rep_next  = COUNT_WIDTH'(1);
            tick_next = '0;
            ph_next   = PH_LONG;
          end
        end else begin
          tick_next = '0;
          ph_next   = PH_RFILT;
        end
      end
      PH_LONG: begin
        if (down) begin
          tick_next = tick_inc;
          if (lp_on && tick_w >= lp_w) begin
            tick_next = '0;
            rep_next  = rep_inc;
            ev_hit    = 1'b1;
            ev_kind   = EV_LONG;
            if (rl_on && rep_w >= rl_w && hs_on) begin
              ph_next = PH_FAST;
            end
          end
        end else begin
          tick_next = '0;
          ph_next   = PH_RFILT;
        end
      end
      PH_FAST: begin
        if (down) begin
          tick_next = tick_inc;
          if (hs_on && tick_w >= hs_w) begin
            tick_next = '0;
            ev_hit    = 1'b1;
            ev_kind   = EV_FAST;
          end
        end else begin
          tick_next = '0;
          ph_next   = PH_RFILT;
        end
      end
      PH_RFILT: begin
        // release is not re-checked here
        tick_next = tick_inc;
        if (tick_w >= filt_w) begin
          ev_hit  = 1'b1;
          ev_kind = EV_LEAVE;
          ph_next = PH_RDONE;
        end
      end
      PH_RDONE: begin
        ph_next = PH_IDLE;
      end
      default: begin
        ph_next = PH_IDLE;
      end
    endcase
  end

  assign tick_stall = (state != F_IDLE);
  assign tick_acc   = tick_valid && !tick_stall;
  assign ev_now     = (state == F_WALK) && p_valid && ev_hit;
  // stall the walk only when a second event needs the queue and it is full
  assign adv        = !(ev_now && hold_valid && q_full);
  assign rd_addr    = rd_cnt[IW-1:0];
  assign rd_en      = (state == F_WALK) && adv && (rd_cnt != LAST_CNT);
  assign wr_en      = (state == F_WALK) && p_valid && adv;

  assign push = hold_valid && !q_full && (ev_now || (state == F_FLUSH));
  assign push_data = '{key: hold_key, kind: hold_kind, last: (state == F_FLUSH)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      phase_mem[p_idx] <= ph_next;
      tick_mem[p_idx]  <= tick_next;
      rep_mem[p_idx]   <= rep_next;
    end
    if (rd_en) begin
      rd_phase <= phase_mem[rd_addr];
      rd_tick  <= tick_mem[rd_addr];
      rd_rep   <= rep_mem[rd_addr];
      p_idx    <= rd_addr;
    end
    if (tick_acc) begin
      keys <= pressed_keys;
    end
    if (ev_now && adv) begin
      hold_key  <= KEY_INDEX_W'(p_idx);
      hold_kind <= ev_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      rd_cnt     <= '0;
      p_valid    <= 1'b0;
      p_seen     <= 1'b0;
      hold_valid <= 1'b0;
      key_vld    <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (tick_acc) begin
            state  <= F_WALK;
            rd_cnt <= '0;
          end
        end
        F_WALK: begin
          if (adv) begin
            if (rd_cnt != LAST_CNT) begin
              p_valid <= 1'b1;
              p_seen  <= key_vld[rd_addr];
              rd_cnt  <= rd_cnt + NW'(1);
            end else begin
              p_valid <= 1'b0;
            end
            if (p_valid && rd_cnt == LAST_CNT) begin
              state <= F_FLUSH;
            end
            if (wr_en) begin
              key_vld[p_idx] <= 1'b1;
            end
            if (ev_now) begin
              hold_valid <= 1'b1;
            end
          end
        end
        F_FLUSH: begin
          if (!hold_valid || !q_full) begin
            hold_valid <= 1'b0;
            state      <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  a_push_held: assert property (@(posedge clk) disable iff (rst)
    push |-> hold_valid)
    else $error("push without a held event");

  a_pvalid_walk: assert property (@(posedge clk) disable iff (rst)
    (state != F_WALK) |-> !p_valid)
    else $error("key in process outside walk");

  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> (state == F_WALK) && (rd_cnt == '0) && !p_valid)
    else $error("walk did not start from key zero");

endmodule

// ----- rtl/core/kprd_evq.sv -----
module kprd_evq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kprd_pkg::event_t push_data,
  output logic             full,
  input  logic             pop,
  output kprd_pkg::event_t head,
  output logic             empty
);
  import kprd_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] LAST_PTR = QW'(QUEUE_DEPTH - 1);

  event_t        entry [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + QW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("event queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("event queue count out of range");

endmodule

// ----- rtl/core/kprd_back.sv -----
module kprd_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  kprd_pkg::event_t                 head,
  output logic                             pop,
  output logic                             event_valid,
  input  logic                             event_stall,
  output logic [kprd_pkg::KEY_INDEX_W-1:0] key_index,
  output logic [1:0]                       event_kind,
  output logic                             last_event
);
  import kprd_pkg::*;

  logic load;

  // refill the output register when it is empty or being taken
  assign load = !q_empty && (!event_valid || !event_stall);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_index  <= head.key;
      event_kind <= head.kind;
      last_event <= head.last;
    end
  end

endmodule

// ----- sim/kprd_event_checker.sv -----
`timescale 1ns / 1ps

// Watches the tick, event and config channels of the keypad detector. It keeps
// its own copy of the per-key debounce/repeat state and the shared registers,
// queues the events each accepted tick should raise, and compares them in order.
module kprd_event_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  input  logic                             tick_stall,
  input  logic [kprd_pkg::KEY_INPUTS-1:0]  pressed_keys,
  input  logic                             event_valid,
  input  logic                             event_stall,
  input  logic [kprd_pkg::KEY_INDEX_W-1:0] key_index,
  input  logic [1:0]                       event_kind,
  input  logic                             last_event,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [kprd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kprd_pkg::CFG_W-1:0]       cfg_data,
  output int                               bad_events,
  output int                               events_due
);
  import kprd_pkg::*;

  typedef enum logic [2:0] {
    KS_IDLE, KS_PRESS_FILT, KS_HELD, KS_LONG_REP,
    KS_FAST_REP, KS_REL_FILT, KS_REL_DONE, KS_UNUSED
  } key_state_t;

  localparam logic [CFG_W-1:0] COUNT_MAX = '1;

  key_state_t       key_state [KEY_INPUTS];
  logic [CFG_W-1:0] hold_ticks [KEY_INPUTS];
  logic [CFG_W-1:0] long_hits [KEY_INPUTS];
  cfg_t             regs;
  event_t           due_events [$];
  int               fail_count = 0;
  int               due_count = 0;

  assign bad_events = fail_count;
  assign events_due = due_count;

  function automatic logic [CFG_W-1:0] bump(input logic [CFG_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + CFG_W'(1);
  endfunction

  // One scan tick: walk the keys in order, queue their events, flag the last.
  task automatic advance_keys(input logic [KEY_INPUTS-1:0] keys);
    key_state_t       st;
    logic [CFG_W-1:0] tc;
    logic [CFG_W-1:0] rc;
    logic             down;
    logic             fire;
    ev_kind_t         kind;
    event_t           held;
    logic             have_held;
    have_held = 1'b0;
    held = '0;
    for (int k = 0; k < KEY_INPUTS; k++) begin
      st = key_state[k];
      tc = hold_ticks[k];
      rc = long_hits[k];
      down = keys[k];
      fire = 1'b0;
      kind = EV_PRESS;
      case (st)
        KS_IDLE: begin
          tc = '0;
          if (down) begin
            tc = CFG_W'(1);
            st = KS_PRESS_FILT;
          end
        end
        KS_PRESS_FILT: begin
          tc = bump(tc);
          if (tc >= regs.filter_time) begin
            if (down) begin
              fire = 1'b1;
              kind = EV_PRESS;
              st = KS_HELD;
            end else begin
              st = KS_IDLE;
            end
          end
        end
        KS_HELD, KS_LONG_REP, KS_FAST_REP: begin
          if (!down) begin
            tc = '0;
            st = KS_REL_FILT;
          end else begin
            tc = bump(tc);
            if (st == KS_FAST_REP) begin
              if (regs.high_speed_period != 0 && tc >= regs.high_speed_period) begin
                tc = '0;
                fire = 1'b1;
                kind = EV_FAST;
              end
            end else if (regs.long_press_time != 0 && tc >= regs.long_press_time) begin
              tc = '0;
              fire = 1'b1;
              kind = EV_LONG;
              if (st == KS_HELD) begin
                rc = CFG_W'(1);
                st = KS_LONG_REP;
              end else begin
                rc = bump(rc);
                if (regs.repeat_limit != 0 && rc >= regs.repeat_limit &&
                    regs.high_speed_period != 0)
                  st = KS_FAST_REP;
              end
            end
          end
        end
        // release is not looked at again while filtering
        KS_REL_FILT: begin
          tc = bump(tc);
          if (tc >= regs.filter_time) begin
            fire = 1'b1;
            kind = EV_LEAVE;
            st = KS_REL_DONE;
          end
        end
        default: st = KS_IDLE;
      endcase
      key_state[k] = st;
      hold_ticks[k] = tc;
      long_hits[k] = rc;
      if (fire) begin
        if (have_held) due_events.push_back(held);
        held = '{key: KEY_INDEX_W'(k), kind: kind, last: 1'b0};
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      due_events.push_back(held);
    end
  endtask

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      for (int k = 0; k < KEY_INPUTS; k++) begin
        key_state[k] = KS_IDLE;
        hold_ticks[k] = '0;
        long_hits[k] = '0;
      end
      regs.filter_time = FILTER_TIME_RST;
      regs.long_press_time = LONG_PRESS_TIME_RST;
      regs.repeat_limit = REPEAT_LIMIT_RST;
      regs.high_speed_period = HIGH_SPEED_PERIOD_RST;
      due_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_TIME:       regs.filter_time = cfg_data;
          REG_LONG_PRESS_TIME:   regs.long_press_time = cfg_data;
          REG_REPEAT_LIMIT:      regs.repeat_limit = cfg_data;
          REG_HIGH_SPEED_PERIOD: regs.high_speed_period = cfg_data;
          default: ;
        endcase
      end
      if (event_valid && !event_stall) begin
        if (due_events.size() == 0) begin
          fail_count++;
          $display("%0t: event with none expected: key %0d kind %0d last %0d",
                   $time, key_index, event_kind, last_event);
        end else begin
          want = due_events.pop_front();
          if (key_index !== want.key) begin
            fail_count++;
            $display("%0t: key_index expected %0d actual %0d",
                     $time, want.key, key_index);
          end
          if (event_kind !== want.kind) begin
            fail_count++;
            $display("%0t: event_kind expected %0d actual %0d (key %0d)",
                     $time, want.kind, event_kind, want.key);
          end
          if (last_event !== want.last) begin
            fail_count++;
            $display("%0t: last_event expected %0d actual %0d (key %0d)",
                     $time, want.last, last_event, want.key);
          end
        end
      end
      if (tick_valid && !tick_stall) advance_keys(pressed_keys);
    end
    due_count = due_events.size();
  end

endmodule

// ----- sim/keypad_press_repeat_detector_tb.sv -----
`timescale 1ns / 1ps

module keypad_press_repeat_detector_tb;
  import kprd_pkg::*;

  // Idle time after the last expected event before touching the registers:
  // a tick with no events can still be walking the keys.
  localparam int DRAIN_CYCLES = 2 * (KEY_INPUTS + 4);

  // Out-of-map register indexes, must be ignored by the block
  localparam logic [CFG_INDEX_W-1:0] NO_REG_FIRST = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] NO_REG_LAST  = 8'hFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   tick_valid = 1'b0;
  logic                   tick_stall;
  logic [KEY_INPUTS-1:0]  pressed_keys = '0;
  logic                   event_valid;
  logic                   event_stall = 1'b0;
  logic [KEY_INDEX_W-1:0] key_index;
  logic [1:0]             event_kind;
  logic                   last_event;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int bad_events;
  int events_due;

  // Per-key press/release pattern for the random part: each key holds its
  // level for a random number of ticks, then flips.
  logic [KEY_INPUTS-1:0] key_level = '0;
  int                    hold_left [KEY_INPUTS];
  bit                    gaps_on = 1'b1;

  // Event receiver backpressure
  int stall_left = 0;
  bit stall_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keypad_press_repeat_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .pressed_keys (pressed_keys),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .key_index    (key_index),
    .event_kind   (event_kind),
    .last_event   (last_event),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  kprd_event_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .pressed_keys (pressed_keys),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .key_index    (key_index),
    .event_kind   (event_kind),
    .last_event   (last_event),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bad_events   (bad_events),
    .events_due   (events_due)
  );

  // Receiver stalls: mostly short bursts, now and then a long one, and
  // stretches with no stall at all (stall_on flips at random times).
  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) stall_on <= !stall_on;
    if (stall_left != 0) begin
      event_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      event_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 2);
    end else begin
      event_stall <= 1'b0;
    end
  end

  // Gap between tick requests; zero keeps tick_valid up for back-to-back.
  task automatic tick_gap();
    int n;
    n = 0;
    if (gaps_on && $urandom_range(0, 2) == 0)
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
    if (n != 0) begin
      tick_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One tick request. Stall is looked at on the falling edge, where it is
  // settled; the request goes through on the following rising edge.
  task automatic send_tick(input logic [KEY_INPUTS-1:0] keys);
    tick_valid <= 1'b1;
    pressed_keys <= keys;
    @(negedge clk);
    while (tick_stall) @(negedge clk);
    @(posedge clk);
    tick_gap();
  endtask

  // One register write request; cfg_valid is left high for the caller.
  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // All four registers, then a junk index that must not alias onto any of them.
  task automatic set_regs(input logic [CFG_W-1:0] filt, input logic [CFG_W-1:0] long_t,
                          input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] fast,
                          input logic [CFG_INDEX_W-1:0] junk_idx);
    cfg_put(REG_FILTER_TIME, filt);
    cfg_put(REG_LONG_PRESS_TIME, long_t);
    cfg_put(REG_REPEAT_LIMIT, limit);
    cfg_put(REG_HIGH_SPEED_PERIOD, fast);
    cfg_put(junk_idx, CFG_W'($urandom));
    cfg_valid <= 1'b0;
    gaps_on = ($urandom_range(0, 3) != 0);
  endtask

  // Stop sending, wait for every expected event, then let the walk finish.
  task automatic settle();
    tick_valid <= 1'b0;
    @(negedge clk);
    while (events_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_INDEX_W-1:0] junk_index();
    return CFG_INDEX_W'($urandom_range(NO_REG_FIRST, NO_REG_LAST));
  endfunction

  // Mostly clean press/hold/release sequences per key; some ticks get contact
  // bounce on a few bits, a few are pure noise, and some press every key.
  task automatic random_ticks(input int count, input int hold_max);
    logic [KEY_INPUTS-1:0] keys;
    repeat (count) begin
      for (int k = 0; k < KEY_INPUTS; k++) begin
        if (hold_left[k] <= 0) begin
          key_level[k] = !key_level[k];
          hold_left[k] = $urandom_range(1, hold_max);
          if ($urandom_range(0, 7) == 0) hold_left[k] = hold_left[k] * 3;
        end
        hold_left[k] = hold_left[k] - 1;
      end
      keys = key_level;
      case ($urandom_range(0, 15))
        0:       keys = KEY_INPUTS'($urandom);
        1, 2:    keys = keys ^ KEY_INPUTS'($urandom & $urandom & $urandom);
        3:       keys = '1;
        default: ;
      endcase
      send_tick(keys);
    end
  endtask

  initial begin
    for (int k = 0; k < KEY_INPUTS; k++) hold_left[k] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: short periods so every event kind shows up within a few ticks.
    set_regs(16'd2, 16'd2, 16'd2, 16'd1, NO_REG_LAST);
    send_tick('1);                  // all keys into press filter
    send_tick('1);                  // press on all 28 keys in one tick
    send_tick('1);                  // first long press
    send_tick('1);
    send_tick('1);                  // second long, repeat limit -> high speed
    send_tick('1);                  // high-speed repeat
    send_tick('0);                  // release starts filter
    send_tick('1);                  // pressed again, filter keeps counting
    send_tick('1);                  // leave on all keys anyway
    send_tick('0);                  // release done -> idle
    send_tick(28'h5555555);         // even keys start filtering
    send_tick(28'h0000000);         // gone before filter ends: no event
    send_tick(28'hAAAAAAA);
    send_tick(28'hAAAAAAA);         // odd keys pressed
    send_tick(28'h0000001);         // odd keys released, key 0 starts filter
    send_tick(28'h0000000);         // key 0 drops out silently
    send_tick(28'h0000000);         // odd keys leave
    send_tick(28'h0000000);
    settle();

    // Reset values written back explicitly
    set_regs(FILTER_TIME_RST, LONG_PRESS_TIME_RST, REPEAT_LIMIT_RST,
             HIGH_SPEED_PERIOD_RST, junk_index());
    random_ticks(60, 40);
    settle();

    // Low extremes: zero filter acts like one tick
    set_regs(16'd0, 16'd1, 16'd1, 16'd1, junk_index());
    random_ticks(50, 6);
    settle();

    // High extremes: keys get parked in the filters
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, junk_index());
    random_ticks(25, 10);
    settle();

    // Main run: press, long, high speed all reachable within a hold
    set_regs(16'd3, 16'd5, 16'd2, 16'd3, junk_index());
    random_ticks(150, 25);
    settle();

    // Long press and high speed both disabled
    set_regs(16'd2, 16'd0, 16'd0, 16'd0, junk_index());
    random_ticks(50, 8);
    settle();

    // Repeat limit zero: long repeats forever
    set_regs(16'd1, 16'd4, 16'd0, 16'd2, junk_index());
    random_ticks(60, 15);
    settle();

    // High-speed period zero: limit reached but mode not entered
    set_regs(16'd2, 16'd3, 16'd3, 16'd0, junk_index());
    random_ticks(60, 20);
    settle();

    if (bad_events == 0 && events_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- keypad_press_repeat_detector.f -----
rtl/core/kprd_pkg.sv
rtl/core/kprd_front.sv
rtl/core/kprd_evq.sv
rtl/core/kprd_back.sv
rtl/core/keypad_press_repeat_detector.sv
sim/kprd_event_checker.sv
sim/keypad_press_repeat_detector_tb.sv
